// File: sv/yuyv_to_rgb_converter_defines.svh
// ----------------------------------------------------------------------------
// YUYV to RGB converter assertion macros
// Shared concurrent assertion shorthands for the converter RTL.
// ----------------------------------------------------------------------------
`ifndef YUYV_TO_RGB_CONVERTER_DEFINES_SVH
`define YUYV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define YUV_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define YUV_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`else

`define YUV_ASSERT_IMPLY(label, clk, rst, pre, post)
`define YUV_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// File: sv/yuyv_pkg.sv
// ----------------------------------------------------------------------------
// YUYV converter package
// Word types, widths, coefficients and the round-and-clamp helper.
// ----------------------------------------------------------------------------
package yuyv_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int POS_WIDTH     = $clog2(MAX_DIMENSION);
   localparam int EFF_WIDTH     = POS_WIDTH + 1;
   localparam int SIZE_WIDTH    = 13;
   localparam int TERM_WIDTH    = 18;
   localparam int SUM_WIDTH     = 20;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [SIZE_WIDTH-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_WIDTH-1:0] HEIGHT_RESET = 13'd480;

   localparam logic signed [TERM_WIDTH-1:0] COEF_LUMA    = 18'sd298;
   localparam logic signed [TERM_WIDTH-1:0] COEF_RED_V   = 18'sd409;
   localparam logic signed [TERM_WIDTH-1:0] COEF_GREEN_U = 18'sd100;
   localparam logic signed [TERM_WIDTH-1:0] COEF_GREEN_V = 18'sd208;
   localparam logic signed [TERM_WIDTH-1:0] COEF_BLUE_U  = 18'sd516;
   localparam logic signed [TERM_WIDTH-1:0] ROUND_BIAS   = 18'sd128;
   localparam logic [7:0] LUMA_OFFSET   = 8'd16;
   localparam logic [7:0] CHROMA_OFFSET = 8'd128;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
      logic       second_valid;
      logic       end_of_row;
      logic       end_of_frame;
   } rsp_word_type;

   typedef struct packed {
      logic second_valid;
      logic end_of_row;
      logic end_of_frame;
   } pos_flags_type;

   typedef struct packed {
      logic signed [TERM_WIDTH-1:0] red_term;
      logic signed [TERM_WIDTH-1:0] green_term;
      logic signed [TERM_WIDTH-1:0] blue_term;
   } chroma_terms_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // floor(sum / 256), limited to 0..255
   function automatic logic [7:0] round_clamp(logic signed [SUM_WIDTH-1:0] sum);
      logic signed [SUM_WIDTH-9:0] quot;
      logic [7:0] result;
      quot = sum[SUM_WIDTH-1:8];
      if (quot < 0) begin
         result = 8'd0;
      end else if (quot > $signed((SUM_WIDTH-8)'(255))) begin
         result = 8'd255;
      end else begin
         result = quot[7:0];
      end
      return result;
   endfunction

endpackage

// File: sv/yuyv_lane.sv
// ----------------------------------------------------------------------------
// YUYV converter pixel lane
// Luma product stage and per-channel sum, round and clamp for one pixel.
// ----------------------------------------------------------------------------
module yuyv_lane (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [7:0]                 luma,
   input  yuyv_pkg::chroma_terms_type chroma_terms,
   output yuyv_pkg::pixel_type        pixel
);

   logic signed [8:0]                     luma_centered;
   logic signed [yuyv_pkg::TERM_WIDTH-1:0] luma_ext;
   logic signed [yuyv_pkg::TERM_WIDTH-1:0] luma_prod_in;
   logic signed [yuyv_pkg::TERM_WIDTH-1:0] luma_prod_ff;
   logic signed [yuyv_pkg::SUM_WIDTH-1:0]  luma_sum;

   assign luma_centered = $signed({1'b0, luma}) - $signed({1'b0, yuyv_pkg::LUMA_OFFSET});
   assign luma_ext      = yuyv_pkg::TERM_WIDTH'(luma_centered);
   assign luma_prod_in  = luma_ext * yuyv_pkg::COEF_LUMA;

   // hold the product while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (enable) begin
         luma_prod_ff <= luma_prod_in;
      end
   end

   assign luma_sum = yuyv_pkg::SUM_WIDTH'(luma_prod_ff);

   always_comb begin
      pixel.red   = yuyv_pkg::round_clamp(luma_sum
                       + yuyv_pkg::SUM_WIDTH'(chroma_terms.red_term));
      pixel.green = yuyv_pkg::round_clamp(luma_sum
                       + yuyv_pkg::SUM_WIDTH'(chroma_terms.green_term));
      pixel.blue  = yuyv_pkg::round_clamp(luma_sum
                       + yuyv_pkg::SUM_WIDTH'(chroma_terms.blue_term));
   end

endmodule

// File: sv/yuyv_position.sv
// ----------------------------------------------------------------------------
// YUYV converter frame position
// Size registers, column and row counters and the per-pair frame marks.
// ----------------------------------------------------------------------------
module yuyv_position (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [yuyv_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [yuyv_pkg::SIZE_WIDTH-1:0]       csr_data,
   input  logic                                  advance,
   output yuyv_pkg::pos_flags_type               flags
);

   logic [yuyv_pkg::SIZE_WIDTH-1:0] width_ff, width_in;
   logic [yuyv_pkg::SIZE_WIDTH-1:0] height_ff, height_in;
   logic [yuyv_pkg::POS_WIDTH-1:0]  column_ff, column_in;
   logic [yuyv_pkg::POS_WIDTH-1:0]  row_ff, row_in;
   logic [yuyv_pkg::EFF_WIDTH-1:0]  eff_width;
   logic [yuyv_pkg::EFF_WIDTH-1:0]  eff_height;
   logic [yuyv_pkg::EFF_WIDTH:0]    column_plus1;
   logic [yuyv_pkg::EFF_WIDTH:0]    column_plus2;
   logic [yuyv_pkg::EFF_WIDTH:0]    row_plus1;

   // saturate the size registers to 1..MAX_DIMENSION
   always_comb begin
      if (width_ff == '0) begin
         eff_width = yuyv_pkg::EFF_WIDTH'(1);
      end else if (32'(width_ff) > 32'(yuyv_pkg::MAX_DIMENSION)) begin
         eff_width = yuyv_pkg::EFF_WIDTH'(yuyv_pkg::MAX_DIMENSION);
      end else begin
         eff_width = yuyv_pkg::EFF_WIDTH'(width_ff);
      end
      if (height_ff == '0) begin
         eff_height = yuyv_pkg::EFF_WIDTH'(1);
      end else if (32'(height_ff) > 32'(yuyv_pkg::MAX_DIMENSION)) begin
         eff_height = yuyv_pkg::EFF_WIDTH'(yuyv_pkg::MAX_DIMENSION);
      end else begin
         eff_height = yuyv_pkg::EFF_WIDTH'(height_ff);
      end
   end

   assign column_plus1 = (yuyv_pkg::EFF_WIDTH+1)'(column_ff) + (yuyv_pkg::EFF_WIDTH+1)'(1);
   assign column_plus2 = (yuyv_pkg::EFF_WIDTH+1)'(column_ff) + (yuyv_pkg::EFF_WIDTH+1)'(2);
   assign row_plus1    = (yuyv_pkg::EFF_WIDTH+1)'(row_ff) + (yuyv_pkg::EFF_WIDTH+1)'(1);

   always_comb begin
      flags.second_valid = column_plus1 < (yuyv_pkg::EFF_WIDTH+1)'(eff_width);
      flags.end_of_row   = column_plus2 >= (yuyv_pkg::EFF_WIDTH+1)'(eff_width);
      flags.end_of_frame = flags.end_of_row
                           && (row_plus1 >= (yuyv_pkg::EFF_WIDTH+1)'(eff_height));
   end

   // advance the counters by one pair
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (advance) begin
         if (flags.end_of_row) begin
            column_in = '0;
            row_in    = flags.end_of_frame ? '0 : yuyv_pkg::POS_WIDTH'(row_plus1);
         end else begin
            column_in = yuyv_pkg::POS_WIDTH'(column_plus2);
         end
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            yuyv_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_data;
            yuyv_pkg::CSR_IMAGE_HEIGHT: height_in = csr_data;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= yuyv_pkg::WIDTH_RESET;
         height_ff <= yuyv_pkg::HEIGHT_RESET;
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

// File: sv/yuyv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// YUYV to RGB converter
// Two-lane BT.601 studio-range YUYV to RGB conversion with frame marks.
// ----------------------------------------------------------------------------
//
//   channel  ports                        word                 direction
//   -------  ---------------------------  -------------------  ---------
//   req      req_valid/req_stall/req_word one YUYV macropixel  in
//   rsp      rsp_valid/rsp_stall/rsp_word two RGB pixels+marks out
//   csr      csr_write/csr_index/csr_data width or height      in
//
// One word per clock while rsp does not stall; an accepted word passes the
// chroma/luma product stage, then the sum-clamp-merge output register.
// Reset (synchronous) empties both stages, zeroes the counters and loads
// the size registers with 640 x 480.
// A stall on rsp holds the output register; req stalls only when the
// product stage is full and cannot drain into the output register.
//
module yuyv_to_rgb_converter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  yuyv_pkg::req_word_type               req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output yuyv_pkg::rsp_word_type               rsp_word,
   input  logic                                 csr_write,
   input  logic [yuyv_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [yuyv_pkg::SIZE_WIDTH-1:0]      csr_data
);

`include "yuyv_to_rgb_converter_defines.svh"

   // pipeline control
   logic rsp_load;
   logic s1_load;
   logic req_accept;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // product stage payload
   yuyv_pkg::pos_flags_type    pos_flags;
   yuyv_pkg::pos_flags_type    s1_flags_ff;
   yuyv_pkg::chroma_terms_type chroma_terms_in;
   yuyv_pkg::chroma_terms_type chroma_terms_ff;
   yuyv_pkg::pixel_type        pixel_first;
   yuyv_pkg::pixel_type        pixel_second;
   yuyv_pkg::rsp_word_type     rsp_word_ff, rsp_word_in;

   logic signed [8:0]                      blue_diff;
   logic signed [8:0]                      red_diff;
   logic signed [yuyv_pkg::TERM_WIDTH-1:0] blue_ext;
   logic signed [yuyv_pkg::TERM_WIDTH-1:0] red_ext;

   // advance the output register when empty or drained; advance stage one
   // when it is empty or can move forward
   assign rsp_load   = !rsp_valid_ff || !rsp_stall;
   assign s1_load    = !s1_valid_ff || rsp_load;
   assign req_stall  = !s1_load;
   assign req_accept = req_valid && s1_load;

   assign s1_valid_in  = s1_load ? req_valid : s1_valid_ff;
   assign rsp_valid_in = rsp_load ? s1_valid_ff : rsp_valid_ff;

   // frame position: marks come from the counters at accept time
   yuyv_position u_position (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .advance   (req_accept),
      .flags     (pos_flags)
   );

   // shared chroma terms, rounding bias folded in
   assign blue_diff = $signed({1'b0, req_word.chroma_blue})
                      - $signed({1'b0, yuyv_pkg::CHROMA_OFFSET});
   assign red_diff  = $signed({1'b0, req_word.chroma_red})
                      - $signed({1'b0, yuyv_pkg::CHROMA_OFFSET});
   assign blue_ext  = yuyv_pkg::TERM_WIDTH'(blue_diff);
   assign red_ext   = yuyv_pkg::TERM_WIDTH'(red_diff);

   always_comb begin
      chroma_terms_in.red_term   = red_ext * yuyv_pkg::COEF_RED_V + yuyv_pkg::ROUND_BIAS;
      chroma_terms_in.green_term = yuyv_pkg::ROUND_BIAS
                                   - blue_ext * yuyv_pkg::COEF_GREEN_U
                                   - red_ext * yuyv_pkg::COEF_GREEN_V;
      chroma_terms_in.blue_term  = blue_ext * yuyv_pkg::COEF_BLUE_U + yuyv_pkg::ROUND_BIAS;
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         chroma_terms_ff <= chroma_terms_in;
         s1_flags_ff     <= pos_flags;
      end
   end

   // one lane per pixel of the pair
   yuyv_lane u_lane_first (
      .clock        (clock),
      .enable       (s1_load),
      .luma         (req_word.luma_first),
      .chroma_terms (chroma_terms_ff),
      .pixel        (pixel_first)
   );

   yuyv_lane u_lane_second (
      .clock        (clock),
      .enable       (s1_load),
      .luma         (req_word.luma_second),
      .chroma_terms (chroma_terms_ff),
      .pixel        (pixel_second)
   );

   // merge both lanes and the marks into one result word
   always_comb begin
      rsp_word_in.red_first    = pixel_first.red;
      rsp_word_in.green_first  = pixel_first.green;
      rsp_word_in.blue_first   = pixel_first.blue;
      rsp_word_in.red_second   = pixel_second.red;
      rsp_word_in.green_second = pixel_second.green;
      rsp_word_in.blue_second  = pixel_second.blue;
      rsp_word_in.second_valid = s1_flags_ff.second_valid;
      rsp_word_in.end_of_row   = s1_flags_ff.end_of_row;
      rsp_word_in.end_of_frame = s1_flags_ff.end_of_frame;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a stall toward req only happens with a full product stage
   `YUV_ASSERT_IMPLY(a_stall_needs_full, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff)
   // a word leaving stage one lands in the output register
   `YUV_ASSERT_NEXT(a_stage_moves, clock, reset, s1_valid_ff && rsp_load, rsp_valid_ff)
   // frame end is always a row end
   `YUV_ASSERT_IMPLY(a_frame_in_row, clock, reset, rsp_valid_ff && rsp_word_ff.end_of_frame, rsp_word_ff.end_of_row)
   // a clipped odd pixel only appears at the end of a row
   `YUV_ASSERT_IMPLY(a_clip_at_row_end, clock, reset, rsp_valid_ff && !rsp_word_ff.second_valid, rsp_word_ff.end_of_row)

endmodule

// File: tb/rgb_pair_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB pair checker
// Watches the size writes and both word channels of the YUYV to RGB converter.
// It predicts every RGB pair from its own copy of the frame counters and
// compares each result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_pair_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  yuyv_pkg::req_word_type               req_word,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  yuyv_pkg::rsp_word_type               rsp_word,
   input  logic                                 csr_write,
   input  logic [yuyv_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [yuyv_pkg::SIZE_WIDTH-1:0]      csr_data,
   output int                                   pair_errors,
   output int                                   pairs_pending,
   output int                                   pairs_checked,
   output int                                   frames_seen
);

   logic [yuyv_pkg::SIZE_WIDTH-1:0] frame_width;
   logic [yuyv_pkg::SIZE_WIDTH-1:0] frame_height;
   int unsigned                     next_column;
   int unsigned                     next_row;
   yuyv_pkg::rsp_word_type          rgb_pairs[$];
   yuyv_pkg::rsp_word_type          oldest_pair;
   int                              errors;
   int                              checked;
   int                              frames;

   // saturate a size register to 1..MAX_DIMENSION
   function automatic int unsigned usable_size(logic [yuyv_pkg::SIZE_WIDTH-1:0] value);
      if (value == 0) return 1;
      if (value > yuyv_pkg::MAX_DIMENSION) return yuyv_pkg::MAX_DIMENSION;
      return 32'(value);
   endfunction

   // floor divide by 256, then limit to one byte
   function automatic logic [7:0] clamp_channel(int sum);
      int quot;
      quot = sum >>> 8;
      if (quot < 0) return 8'd0;
      if (quot > 255) return 8'd255;
      return quot[7:0];
   endfunction

   function automatic yuyv_pkg::pixel_type convert_pixel(logic [7:0] luma, int d, int e);
      int                  c;
      yuyv_pkg::pixel_type p;
      c = int'(luma) - 16;
      p.red   = clamp_channel(298 * c + 409 * e + 128);
      p.green = clamp_channel(298 * c - 100 * d - 208 * e + 128);
      p.blue  = clamp_channel(298 * c + 516 * d + 128);
      return p;
   endfunction

   // predict one pair and advance the frame position
   function automatic yuyv_pkg::rsp_word_type predict_pair(yuyv_pkg::req_word_type w);
      yuyv_pkg::rsp_word_type r;
      yuyv_pkg::pixel_type    even_px;
      yuyv_pkg::pixel_type    odd_px;
      int                     d;
      int                     e;
      int unsigned            cols;
      int unsigned            rows;
      cols = usable_size(frame_width);
      rows = usable_size(frame_height);
      d = int'(w.chroma_blue) - 128;
      e = int'(w.chroma_red) - 128;
      even_px = convert_pixel(w.luma_first, d, e);
      odd_px  = convert_pixel(w.luma_second, d, e);
      r.red_first    = even_px.red;
      r.green_first  = even_px.green;
      r.blue_first   = even_px.blue;
      r.red_second   = odd_px.red;
      r.green_second = odd_px.green;
      r.blue_second  = odd_px.blue;
      r.second_valid = (next_column + 1) < cols;
      r.end_of_row   = (next_column + 2) >= cols;
      r.end_of_frame = r.end_of_row && (next_row + 1) >= rows;
      if (r.end_of_row) begin
         next_column = 0;
         next_row = r.end_of_frame ? 0 : next_row + 1;
      end else begin
         next_column = next_column + 2;
      end
      return r;
   endfunction

   task automatic flag_field(string name, int want, int got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
   endtask

   task automatic compare_pair(yuyv_pkg::rsp_word_type want, yuyv_pkg::rsp_word_type got);
      if (got.red_first !== want.red_first)
         flag_field("red_first", want.red_first, got.red_first);
      if (got.green_first !== want.green_first)
         flag_field("green_first", want.green_first, got.green_first);
      if (got.blue_first !== want.blue_first)
         flag_field("blue_first", want.blue_first, got.blue_first);
      if (got.red_second !== want.red_second)
         flag_field("red_second", want.red_second, got.red_second);
      if (got.green_second !== want.green_second)
         flag_field("green_second", want.green_second, got.green_second);
      if (got.blue_second !== want.blue_second)
         flag_field("blue_second", want.blue_second, got.blue_second);
      if (got.second_valid !== want.second_valid)
         flag_field("second_valid", want.second_valid, got.second_valid);
      if (got.end_of_row !== want.end_of_row)
         flag_field("end_of_row", want.end_of_row, got.end_of_row);
      if (got.end_of_frame !== want.end_of_frame)
         flag_field("end_of_frame", want.end_of_frame, got.end_of_frame);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_width  = yuyv_pkg::WIDTH_RESET;
         frame_height = yuyv_pkg::HEIGHT_RESET;
         next_column  = 0;
         next_row     = 0;
         rgb_pairs.delete();
         errors  = 0;
         checked = 0;
         frames  = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               yuyv_pkg::CSR_IMAGE_WIDTH:  frame_width = csr_data;
               yuyv_pkg::CSR_IMAGE_HEIGHT: frame_height = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) rgb_pairs.push_back(predict_pair(req_word));
         if (rsp_valid && !rsp_stall) begin
            if (rgb_pairs.size() == 0) begin
               errors++;
               $display("%0t: result word %h with no prediction waiting", $time, rsp_word);
            end else begin
               oldest_pair = rgb_pairs.pop_front();
               compare_pair(oldest_pair, rsp_word);
               checked++;
               if (oldest_pair.end_of_frame) frames++;
            end
         end
      end
      pair_errors   <= errors;
      pairs_pending <= rgb_pairs.size();
      pairs_checked <= checked;
      frames_seen   <= frames;
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// YUYV to RGB converter testbench
// Drives YUYV macropixel words through the converter under a series of frame
// sizes, from one pixel to beyond the largest, with random gaps on both
// channels and one long result hold-off. A separate checker predicts every
// RGB pair with its frame marks and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 12;
   localparam int PIPE_LATENCY   = 2;
   localparam int HOLD_OFF       = 300;
   localparam int HOLD_AT_PAIR   = 1200;
   localparam int WATCHDOG_LIMIT = 5000;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   yuyv_pkg::req_word_type               req_word;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   yuyv_pkg::rsp_word_type               rsp_word;
   logic                                 csr_write;
   logic [yuyv_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [yuyv_pkg::SIZE_WIDTH-1:0]      csr_data;

   int pair_errors;
   int pairs_pending;
   int pairs_checked;
   int frames_seen;
   int size_settings;
   int quiet_cycles;
   bit gaps_enabled;

   yuyv_to_rgb_converter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   rgb_pair_checker pair_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .pair_errors   (pair_errors),
      .pairs_pending (pairs_pending),
      .pairs_checked (pairs_checked),
      .frames_seen   (frames_seen)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Bias bytes toward the clamp corners: zero and full scale show up often.
   function automatic logic [7:0] random_byte();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic yuyv_pkg::req_word_type random_macropixel();
      yuyv_pkg::req_word_type w;
      w.luma_first  = random_byte();
      w.chroma_blue = random_byte();
      w.luma_second = random_byte();
      w.chroma_red  = random_byte();
      return w;
   endfunction

   // Offer one word and hold it until the converter takes it. An optional gap
   // goes in first, so valid only drops at the edge where the last word left.
   task automatic send_macropixel(yuyv_pkg::req_word_type w);
      if (gaps_enabled && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random(int count);
      repeat (count) send_macropixel(random_macropixel());
   endtask

   // Drop valid and wait until every predicted pair has come back.
   task automatic drain_pairs();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pairs_pending != 0) @(posedge clock);
   endtask

   // Write both size registers while the pipe is empty. The counters keep
   // their position, so a smaller size can land in the middle of a frame.
   task automatic set_frame_size(logic [yuyv_pkg::SIZE_WIDTH-1:0] cols,
                                 logic [yuyv_pkg::SIZE_WIDTH-1:0] rows);
      drain_pairs();
      repeat (PIPE_LATENCY + 2) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= yuyv_pkg::CSR_IMAGE_WIDTH;
      csr_data  <= cols;
      @(posedge clock);
      csr_index <= yuyv_pkg::CSR_IMAGE_HEIGHT;
      csr_data  <= rows;
      @(posedge clock);
      csr_write <= 1'b0;
      size_settings++;
   endtask

   // Receiver: random stalls, plus one long hold-off once the run is deep
   // enough that the sender keeps pushing and the converter backs up.
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && pairs_checked >= HOLD_AT_PAIR) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= gaps_enabled && ($urandom_range(99) < 20);
         end
      end
   end

   // Watchdog: end the run if no word moves on either channel for too long.
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("[yuyv_to_rgb_converter] ERROR");
      $finish;
   end

   initial begin
      logic [31:0] corner_words[20];
      logic [yuyv_pkg::SIZE_WIDTH-1:0] cols;
      corner_words = '{
         32'h00000000, 32'hFFFFFFFF, 32'h10801080, 32'hEB80EB80,
         32'h10EB8080, 32'hEB801080, 32'h00FFFF00, 32'hFF00FF00,
         32'h1000EBFF, 32'hEBFF1000, 32'h80008000, 32'h80FF80FF,
         32'h1080EB00, 32'hEB8010FF, 32'h01FE7F80, 32'hFE017F80,
         32'h55AA55AA, 32'hAA55AA55, 32'h11FF1100, 32'h7F7F8181
      };
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_word     = '0;
      csr_write    = 1'b0;
      csr_index    = yuyv_pkg::CSR_IMAGE_WIDTH;
      csr_data     = '0;
      gaps_enabled = 1'b1;
      size_settings = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Corner words under the reset size: black, white, clamp corners,
      // neutral and saturated chroma.
      foreach (corner_words[i]) send_macropixel(yuyv_pkg::req_word_type'(corner_words[i]));

      // Tiny frames: at widths one and two every pair ends a row, one pixel width kills the odd one.
      set_frame_size(13'd1, 13'd1);
      send_random(40);
      set_frame_size(13'd2, 13'd1);
      send_random(40);
      set_frame_size(13'd3, 13'd2);
      send_random(60);
      // Zero acts as one.
      set_frame_size(13'd0, 13'd0);
      send_random(30);

      // Oversized registers saturate to the largest size; run this stretch
      // with no gaps on either side.
      gaps_enabled = 1'b0;
      set_frame_size(13'd8191, 13'd8191);
      send_random(300);
      gaps_enabled = 1'b1;

      // Shrink below the current column: the row must end at once.
      set_frame_size(13'd9, 13'd5);
      send_random(80);
      // Climb many rows, then shrink the height under the current row.
      set_frame_size(13'd4, 13'd50);
      send_random(60);
      set_frame_size(13'd4, 13'd3);
      send_random(40);
      set_frame_size(13'd4096, 13'd2);
      send_random(150);
      set_frame_size(13'd5, 13'd4097);
      send_random(100);

      // Random small frames, now and then an empty or oversized register.
      repeat (9) begin
         case ($urandom_range(9))
            0: cols = 13'd0;
            1: cols = 13'($urandom_range(4090, 8191));
            default: cols = 13'($urandom_range(1, 24));
         endcase
         set_frame_size(cols, 13'($urandom_range(0, 9)));
         send_random($urandom_range(70, 110));
      end

      drain_pairs();
      repeat (PIPE_LATENCY + 4) @(posedge clock);

      $display("checked %0d RGB pairs over %0d complete frames", pairs_checked, frames_seen);
      $display("%0d frame sizes written, including zero, odd widths and oversized values",
               size_settings);
      if (pair_errors == 0 && pairs_pending == 0) begin
         $display("[yuyv_to_rgb_converter] OK");
      end else begin
         $display("[yuyv_to_rgb_converter] ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/yuyv_pkg.sv
sv/yuyv_lane.sv
sv/yuyv_position.sv
sv/yuyv_to_rgb_converter.sv
tb/rgb_pair_checker.sv
tb/testbench.sv
